>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for the concurrent checks of the projection block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define WSP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication, disabled while rst is high
`define WSP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

>>> rtl/core/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// shared types and constants of the world-to-screen projection block
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

   localparam int FIELD_W       = 32;
   localparam int INDEX_W       = 4;
   localparam int MATRIX_DEPTH  = 16;
   localparam int VIEW_W        = 14;
   localparam int HALF_W        = 13;
   localparam int NEAR_W        = 31;
   localparam int CSR_DATA_W    = 31;
   localparam int CSR_INDEX_W   = 2;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = 2;
   localparam int QCOUNT_W      = 3;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_PROJECT = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_VIEWPORT_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEWPORT_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_LIMIT      = 2'd2;

   localparam logic [VIEW_W-1:0] VIEWPORT_WIDTH_RST  = 14'd1920;
   localparam logic [VIEW_W-1:0] VIEWPORT_HEIGHT_RST = 14'd1080;
   localparam logic [NEAR_W-1:0] NEAR_LIMIT_RST      = 31'd6554;

   typedef struct packed {
      logic                      kind;
      logic [INDEX_W-1:0]        coeff_index;
      logic signed [FIELD_W-1:0] coeff_value;
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic                      visible;
      logic signed [FIELD_W-1:0] screen_x;
      logic signed [FIELD_W-1:0] screen_y;
   } rsp_type;

   typedef struct packed {
      logic [HALF_W-1:0] half_width;
      logic [HALF_W-1:0] half_height;
      logic [NEAR_W-1:0] near_limit;
   } cfg_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/core/wsp_front.sv
// ----------------------------------------------------------------------------
// wsp_front
// intake: classifies request beats and saturates them into queue entries
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_front #(
   parameter int VALUE_WIDTH = 32,
   parameter int ENTRY_W     = 5 + 4 * 32
) (
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire wsp_pkg::req_type            req_payload,
   input  wire wsp_pkg::queue_status_type   q_status,
   output logic                             push,
   output logic [ENTRY_W-1:0]               entry
);
   import wsp_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int XW = (VW > FIELD_W) ? VW : FIELD_W;

   // clamp a 32-bit field into the internal value range
   function automatic logic [VW-1:0] sat_in(input logic signed [FIELD_W-1:0] v);
      logic signed [XW-1:0] e;
      logic signed [XW-1:0] hi;
      logic signed [XW-1:0] lo;
      e  = XW'(v);
      hi = XW'({1'b0, {(VW-1){1'b1}}});
      lo = ~hi;
      if (e > hi) begin
         sat_in = hi[VW-1:0];
      end else if (e < lo) begin
         sat_in = lo[VW-1:0];
      end else begin
         sat_in = e[VW-1:0];
      end
   endfunction

   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;
   assign entry     = {req_payload.kind, req_payload.coeff_index,
                       sat_in(req_payload.coeff_value), sat_in(req_payload.pos_x),
                       sat_in(req_payload.pos_y), sat_in(req_payload.pos_z)};

endmodule

`default_nettype wire

>>> rtl/core/wsp_queue.sv
// ----------------------------------------------------------------------------
// wsp_queue
// short fifo between intake and the projection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_queue #(
   parameter int ENTRY_W = 5 + 4 * 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [ENTRY_W-1:0]         din,
   input  wire logic                       pop,
   output logic [ENTRY_W-1:0]              dout,
   output wsp_pkg::queue_status_type       status
);
   import wsp_pkg::*;

   logic [ENTRY_W-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

`default_nettype wire

>>> rtl/core/wsp_div.sv
// ----------------------------------------------------------------------------
// wsp_div
// pipelined restoring divider, one quotient bit per stage, saturated result
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_div #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [VALUE_WIDTH-1:0] num_mag,
   input  wire logic                   num_neg,
   input  wire logic [VALUE_WIDTH-1:0] den,
   output logic [VALUE_WIDTH-1:0]      quot
);
   localparam int VW = VALUE_WIDTH;
   localparam int QB = VALUE_WIDTH + FRAC_BITS;
   localparam logic [QB-1:0] QMAX_POS = {{(QB-VW+1){1'b0}}, {(VW-1){1'b1}}};
   localparam logic [QB-1:0] QMAX_NEG = QB'(1) << (VW - 1);

   logic [VW-2:0] rem_ff [QB];
   logic [QB-1:0] dvd_ff [QB];
   logic [QB-1:0] quo_ff [QB];
   logic [VW-1:0] den_ff [QB];
   logic          neg_ff [QB];
   logic [VW-1:0] quot_ff, quot_in;

   for (genvar s = 0; s < QB; s++) begin : g_stage
      logic [VW-2:0] src_rem;
      logic [QB-1:0] src_dvd;
      logic [QB-1:0] src_quo;
      logic [VW-1:0] src_den;
      logic          src_neg;
      logic [VW-1:0] trial;
      logic          ge;
      logic [VW-2:0] rem_in;

      if (s == 0) begin : g_first
         assign src_rem = '0;
         assign src_dvd = {num_mag, {FRAC_BITS{1'b0}}};
         assign src_quo = '0;
         assign src_den = den;
         assign src_neg = num_neg;
      end else begin : g_next
         assign src_rem = rem_ff[s-1];
         assign src_dvd = dvd_ff[s-1];
         assign src_quo = quo_ff[s-1];
         assign src_den = den_ff[s-1];
         assign src_neg = neg_ff[s-1];
      end

      assign trial  = {src_rem, src_dvd[QB-1]};
      assign ge     = (trial >= src_den);
      assign rem_in = ge ? (VW-1)'(trial - src_den) : trial[VW-2:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            dvd_ff[s] <= {src_dvd[QB-2:0], 1'b0};
            quo_ff[s] <= {src_quo[QB-2:0], ge};
            den_ff[s] <= src_den;
            neg_ff[s] <= src_neg;
         end
      end
   end

   logic [QB-1:0] q_last;
   logic [QB-1:0] q_negated;

   assign q_last    = quo_ff[QB-1];
   assign q_negated = ~q_last + QB'(1);

   always_comb begin
      if (!neg_ff[QB-1]) begin
         quot_in = (q_last > QMAX_POS) ? {1'b0, {(VW-1){1'b1}}} : q_last[VW-1:0];
      end else begin
         quot_in = (q_last > QMAX_NEG) ? {1'b1, {(VW-1){1'b0}}} : q_negated[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

>>> rtl/core/wsp_back.sv
// ----------------------------------------------------------------------------
// wsp_back
// matrix store and projection pipeline with the result register
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_back #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int ENTRY_W     = 5 + 4 * 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 entry_valid,
   input  wire logic [ENTRY_W-1:0]   entry,
   output logic                      pop,
   input  wire wsp_pkg::cfg_type     cfg,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output wsp_pkg::rsp_type          rsp_payload
);
   import wsp_pkg::*;

   localparam int VW   = VALUE_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * VW;
   localparam int MW   = PW - F;
   localparam int CAPW = (MW > 61) ? MW : 61;
   localparam int TW   = CAPW + 1;
   localparam int SW   = TW + 2;
   localparam int NW   = ((VW > NEAR_W) ? VW : NEAR_W) + 1;
   localparam int DL   = VW + F + 1;
   localparam int MXW  = VW + HALF_W + 1;
   localparam int SCW  = ((MXW > HALF_W + F + 1) ? MXW : HALF_W + F + 1) + 1;
   localparam int XW   = (VW > FIELD_W) ? VW : FIELD_W;
   localparam logic [CAPW-1:0] PCAP = CAPW'(1) << 60;

   // row 2 of the matrix never feeds a result
   localparam int ROW_OF [3] = '{0, 1, 3};

   function automatic logic signed [TW-1:0] scale_term(input logic signed [PW-1:0] p);
      logic [PW-1:0]   a;
      logic [CAPW-1:0] m;
      a = p[PW-1] ? (~p) + PW'(1) : p;
      m = CAPW'(a >> F);
      if (m > PCAP) begin
         m = PCAP;
      end
      scale_term = p[PW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   function automatic logic [VW-1:0] sat_sum(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = SW'({1'b0, {(VW-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         sat_sum = hi[VW-1:0];
      end else if (v < lo) begin
         sat_sum = lo[VW-1:0];
      end else begin
         sat_sum = v[VW-1:0];
      end
   endfunction

   function automatic logic [FIELD_W-1:0] sat_scr(input logic signed [SCW-1:0] v);
      logic signed [SCW-1:0] hi;
      logic signed [SCW-1:0] lo;
      logic signed [XW-1:0]  e;
      hi = SCW'({1'b0, {(VW-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         e = XW'($signed(hi[VW-1:0]));
      end else if (v < lo) begin
         e = XW'($signed(lo[VW-1:0]));
      end else begin
         e = XW'($signed(v[VW-1:0]));
      end
      sat_scr = e[FIELD_W-1:0];
   endfunction

   // entry fields
   logic                 e_kind;
   logic [INDEX_W-1:0]   e_index;
   logic signed [VW-1:0] e_coeff;
   logic signed [VW-1:0] e_pos [3];
   logic                 en;
   logic                 rsp_valid_ff;

   assign {e_kind, e_index, e_coeff, e_pos[0], e_pos[1], e_pos[2]} = entry;
   assign en  = !rsp_valid_ff || rsp_ready;
   assign pop = en && entry_valid;

   // matrix store
   logic signed [VW-1:0] mat_ff [MATRIX_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MATRIX_DEPTH; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (pop && e_kind == KIND_LOAD) begin
         mat_ff[e_index] <= e_coeff;
      end
   end

   // pipeline control chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, vis4_ff, vm_ff, vism_ff;
   logic vd_ff [DL];
   logic visd_ff [DL];
   logic vis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DL; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v1_ff        <= pop && e_kind == KIND_PROJECT;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         vd_ff[0]     <= v4_ff;
         for (int i = 1; i < DL; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         vm_ff        <= vd_ff[DL-1];
         rsp_valid_ff <= vm_ff;
      end
   end

   // products, scaled terms, clip sums
   logic signed [PW-1:0] prod_ff [3][3];
   logic signed [VW-1:0] cst1_ff [3];
   logic signed [TW-1:0] term_ff [3][3];
   logic signed [VW-1:0] cst2_ff [3];
   logic [VW-1:0]        clip_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= e_pos[c] * mat_ff[ROW_OF[r]*4 + c];
               term_ff[r][c] <= scale_term(prod_ff[r][c]);
            end
            cst1_ff[r] <= mat_ff[ROW_OF[r]*4 + 3];
            cst2_ff[r] <= cst1_ff[r];
            clip_ff[r] <= sat_sum(SW'(term_ff[r][0]) + SW'(term_ff[r][1])
                                  + SW'(term_ff[r][2]) + SW'(cst2_ff[r]));
         end
      end
   end

   // visibility and divider operands
   logic signed [NW-1:0] cw_x;
   logic signed [NW-1:0] near_x;
   logic [VW-1:0]        magx_ff, magy_ff, den_ff;
   logic                 negx_ff, negy_ff;

   assign cw_x   = NW'($signed(clip_ff[2]));
   assign near_x = NW'(cfg.near_limit);
   assign vis_in = !clip_ff[2][VW-1] && (clip_ff[2] != '0) && (cw_x >= near_x);

   always_ff @(posedge clock) begin
      if (en) begin
         vis4_ff <= vis_in;
         magx_ff <= clip_ff[0][VW-1] ? ~clip_ff[0] + VW'(1) : clip_ff[0];
         magy_ff <= clip_ff[1][VW-1] ? ~clip_ff[1] + VW'(1) : clip_ff[1];
         negx_ff <= clip_ff[0][VW-1];
         negy_ff <= clip_ff[1][VW-1];
         den_ff  <= clip_ff[2];
         visd_ff[0] <= vis4_ff;
         for (int i = 1; i < DL; i++) begin
            visd_ff[i] <= visd_ff[i-1];
         end
      end
   end

   logic [VW-1:0] nx, ny;

   wsp_div #(.VALUE_WIDTH(VW), .FRAC_BITS(F)) u_div_x (
      .clock(clock), .en(en), .num_mag(magx_ff), .num_neg(negx_ff),
      .den(den_ff), .quot(nx)
   );

   wsp_div #(.VALUE_WIDTH(VW), .FRAC_BITS(F)) u_div_y (
      .clock(clock), .en(en), .num_mag(magy_ff), .num_neg(negy_ff),
      .den(den_ff), .quot(ny)
   );

   // viewport scaling and result register
   logic signed [MXW-1:0] mx_ff, my_ff;
   logic signed [SCW-1:0] base_x, base_y, sx, sy;
   rsp_type               rsp_ff;

   assign base_x = SCW'({cfg.half_width, {F{1'b0}}});
   assign base_y = SCW'({cfg.half_height, {F{1'b0}}});
   assign sx     = SCW'(mx_ff) + base_x;
   assign sy     = base_y - SCW'(my_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         vism_ff <= visd_ff[DL-1];
         mx_ff   <= $signed(nx) * $signed({1'b0, cfg.half_width});
         my_ff   <= $signed(ny) * $signed({1'b0, cfg.half_height});
         rsp_ff.visible  <= vism_ff;
         rsp_ff.screen_x <= vism_ff ? sat_scr(sx) : '0;
         rsp_ff.screen_y <= vism_ff ? sat_scr(sy) : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/core/world_to_screen_projection.sv
// throughput: one request beat per cycle, loads and points alike, while the
//   response side takes a beat each cycle
// reset: synchronous, clears the matrix to zero, empties the queue and pipeline
//   and restores the viewport and near-limit registers to their defaults
// ----------------------------------------------------------------------------
// world_to_screen_projection
// projects points through a stored 4x4 matrix onto viewport pixel coordinates
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module world_to_screen_projection #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire wsp_pkg::req_type                     req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output wsp_pkg::rsp_type                          rsp_payload,
   input  wire logic                                 csr_we,
   input  wire logic [wsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [wsp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wsp_pkg::*;

   // queue entry: kind, index, coefficient and three coordinates
   localparam int ENTRY_W = 1 + INDEX_W + 4 * VALUE_WIDTH;

   // configuration registers
   logic [VIEW_W-1:0] view_w_ff, view_w_in;
   logic [VIEW_W-1:0] view_h_ff, view_h_in;
   logic [NEAR_W-1:0] near_ff, near_in;
   cfg_type           cfg;

   always_comb begin
      view_w_in = view_w_ff;
      view_h_in = view_h_ff;
      near_in   = near_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VIEWPORT_WIDTH:  view_w_in = csr_wdata[VIEW_W-1:0];
            CSR_VIEWPORT_HEIGHT: view_h_in = csr_wdata[VIEW_W-1:0];
            CSR_NEAR_LIMIT:      near_in   = csr_wdata[NEAR_W-1:0];
            default: ;           // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_w_ff <= VIEWPORT_WIDTH_RST;
         view_h_ff <= VIEWPORT_HEIGHT_RST;
         near_ff   <= NEAR_LIMIT_RST;
      end else begin
         view_w_ff <= view_w_in;
         view_h_ff <= view_h_in;
         near_ff   <= near_in;
      end
   end

   // integer halves of the viewport
   assign cfg.half_width  = view_w_ff[VIEW_W-1:1];
   assign cfg.half_height = view_h_ff[VIEW_W-1:1];
   assign cfg.near_limit  = near_ff;

   // intake side: classify and saturate, then queue
   logic                 push;
   logic                 pop;
   logic [ENTRY_W-1:0]   entry_in;
   logic [ENTRY_W-1:0]   entry_out;
   queue_status_type     q_status;

   wsp_front #(.VALUE_WIDTH(VALUE_WIDTH), .ENTRY_W(ENTRY_W)) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .entry       (entry_in)
   );

   // queue lets intake keep taking beats while the pipeline is stalled, until its four slots fill
   wsp_queue #(.ENTRY_W(ENTRY_W)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .din    (entry_in),
      .pop    (pop),
      .dout   (entry_out),
      .status (q_status)
   );

   // execution side: loads update the matrix in order with points,
   // points run through multiply, sum, divide and viewport stages
   wsp_back #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (!q_status.empty),
      .entry       (entry_out),
      .pop         (pop),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // checks
   `WSP_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid && q_status.empty)
   `WSP_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, q_status.count <= QCOUNT_W'(QUEUE_DEPTH))
   `WSP_ASSERT_IMP(a_full_blocks, clock, reset, q_status.full, !req_ready && !push)
   `WSP_ASSERT_IMP(a_no_pop_empty, clock, reset, q_status.empty, !pop)

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world-to-screen projection testbench
// streams matrix loads and points through the block under random idling on
// both channels, predicts each screen result and checks them in order
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import wsp_pkg::*;

   localparam int  DRAIN_CYCLES = 70;
   localparam int  CYCLE_LIMIT  = 300000;
   localparam int  RANDOM_ITEMS = 320;
   localparam longint ONE_Q     = 65536;    // 1.0 in Q16.16

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   world_to_screen_projection dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // items waiting to be driven and screen results still owed by the block
   req_type pending_beats[$];
   rsp_type owed_points[$];
   int      mismatches = 0;
   int      cycle_count = 0;

   // predictor state: matrix and register copies
   longint  matrix_q[16];
   longint  half_w = 960;
   longint  half_h = 540;
   longint  near_q = 6554;

   function automatic longint clamp_q(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // exact product, dropped to Q16 with truncation toward zero
   function automatic longint fixed_mul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = (p < 0 ? -p : p) >> 16;
      return (p < 0) ? -m : m;
   endfunction

   function automatic longint clip_sum(int row, longint x, longint y, longint z);
      return clamp_q(fixed_mul(x, matrix_q[row*4]) + fixed_mul(y, matrix_q[row*4+1])
                     + fixed_mul(z, matrix_q[row*4+2]) + matrix_q[row*4+3]);
   endfunction

   // n / w in Q16, truncated toward zero, saturated
   function automatic longint ndc_quotient(longint n, longint w);
      logic [127:0] num, quo;
      longint       q;
      num = 128'(n < 0 ? -n : n) << 16;
      quo = num / 128'(w);
      q = (quo > 128'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : longint'(quo);
      return clamp_q(n < 0 ? -q : q);
   endfunction

   // applies one accepted beat to the predictor, queueing any result it owes
   task automatic predict_beat(req_type b);
      longint  x, y, z, cx, cy, cw, nx, ny;
      rsp_type r;
      if (b.kind == KIND_LOAD) begin
         matrix_q[b.coeff_index] = longint'(b.coeff_value);
      end else begin
         x = longint'(b.pos_x);
         y = longint'(b.pos_y);
         z = longint'(b.pos_z);
         cx = clip_sum(0, x, y, z);
         cy = clip_sum(1, x, y, z);
         cw = clip_sum(3, x, y, z);
         r = '0;
         if (cw > 0 && cw >= near_q) begin
            nx = ndc_quotient(cx, cw);
            ny = ndc_quotient(cy, cw);
            r.visible  = 1'b1;
            r.screen_x = 32'(clamp_q(half_w * nx + (half_w << 16)));
            r.screen_y = 32'(clamp_q(-(half_h * ny) + (half_h << 16)));
         end
         owed_points.push_back(r);
      end
   endtask

   // sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (req_valid && req_ready) predict_beat(req_payload);
      if (reset || (req_valid && !req_ready)) begin
         // hold the offered beat until taken
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
         req_payload <= pending_beats.pop_front();
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: stall pattern re-drawn at random from four modes, plus one long hold-off
   // while the sender is still offering plenty of beats
   int  ready_mode = 0;
   int  long_hold = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) ready_mode <= $urandom_range(0, 3);
      if (!long_hold_done && !reset && pending_beats.size() > 100) begin
         long_hold_done <= 1'b1;
         long_hold <= 300;
         rsp_ready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 4) == 0);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 4) != 0);
            end
         endcase
      end
   end

   // monitor: each result beat against the oldest owed point
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_points.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result beat %p", rsp_payload);
         end else begin
            want = owed_points.pop_front();
            if (rsp_payload.visible !== want.visible
                || rsp_payload.screen_x !== want.screen_x
                || rsp_payload.screen_y !== want.screen_y) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("result mismatch: expected %p, got %p", want, rsp_payload);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_load(int idx, logic [31:0] val);
      req_type b;
      b = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      b.kind = KIND_LOAD;
      b.coeff_index = idx[3:0];
      b.coeff_value = val;
      pending_beats.push_back(b);
   endtask

   task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type b;
      b = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      b.kind = KIND_PROJECT;
      b.pos_x = x;
      b.pos_y = y;
      b.pos_z = z;
      pending_beats.push_back(b);
   endtask

   // sender stops until every owed result is back and the pipe has emptied
   task automatic drain_all();
      while (pending_beats.size() > 0 || req_valid || owed_points.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_viewport(int w, int h, int near);
      csr_index <= CSR_VIEWPORT_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      csr_we <= 1'b1;
      @(posedge clock);
      csr_index <= CSR_VIEWPORT_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_NEAR_LIMIT;
      csr_wdata <= CSR_DATA_W'(near);
      @(posedge clock);
      csr_we <= 1'b0;
      half_w = (w & 16'h3FFF) / 2;
      half_h = (h & 16'h3FFF) / 2;
      near_q = near & 32'h7FFF_FFFF;
   endtask

   // coordinates: mostly near the view volume, some full range and extremes
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 16 * ONE_Q)) - 8 * ONE_Q);
      endcase
   endfunction

   task automatic queue_random_stream(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            // occasional matrix tweak, small coefficients mostly
            queue_load($urandom_range(0, 15), ($urandom_range(0, 7) == 0)
                       ? $urandom : 32'($signed($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q));
         end else begin
            queue_point(pick_coord(), pick_coord(), pick_coord());
         end
      end
   endtask

   task automatic load_camera();
      for (int i = 0; i < 16; i++) queue_load(i, 32'h0);
      queue_load(0, 32'(ONE_Q));
      queue_load(5, 32'(ONE_Q));
      queue_load(14, 32'(ONE_Q));   // clip w follows z
   endtask

   initial begin
      foreach (matrix_q[i]) matrix_q[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero matrix, then a simple camera
      queue_point(32'(ONE_Q), 32'(ONE_Q), 32'(ONE_Q));        // zero w, hidden
      load_camera();
      queue_point(32'(ONE_Q), 32'(ONE_Q), 32'(2 * ONE_Q));    // ordinary visible
      queue_point(32'h0, 32'h0, 32'h0);                       // w zero
      queue_point(32'(ONE_Q), 32'h0, 32'd6554);               // w exactly at near
      queue_point(32'(ONE_Q), 32'h0, 32'd6553);               // just below near
      queue_point(32'(ONE_Q), 32'(-ONE_Q), 32'(-ONE_Q));      // behind camera
      queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd6554);    // quotient saturates
      queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_load(3, 32'h7FFF_FFFF);                           // extreme constant column
      queue_load(1, 32'h8000_0000);
      queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // clip sums saturate
      queue_point(32'h8000_0000, 32'h8000_0000, 32'h0);
      drain_all();

      // near limit zero still hides non-positive w; tiny viewport
      write_viewport(1, 1, 0);
      load_camera();
      queue_point(32'h0, 32'h0, 32'h0);
      queue_point(32'(ONE_Q), 32'(-ONE_Q), 32'd1);
      queue_random_stream(RANDOM_ITEMS / 4);
      drain_all();

      // 8192-pixel viewport, largest near limit
      write_viewport(8192, 8192, 32'h7FFF_FFFF);
      queue_point(32'h0, 32'h0, 32'h7FFF_FFFF);
      queue_random_stream(RANDOM_ITEMS / 8);
      drain_all();

      // zero viewport halves from a zero width and height
      write_viewport(0, 0, 6554);
      queue_random_stream(RANDOM_ITEMS / 8);
      drain_all();

      // random settings, extra large stream for the long receiver hold-off
      write_viewport($urandom_range(1, 8192), $urandom_range(1, 8192),
                     $urandom_range(0, 2 * ONE_Q));
      queue_random_stream(RANDOM_ITEMS / 2);
      drain_all();

      write_viewport(16383, 16383, $urandom_range(0, 32'h7FFF_FFFF));
      queue_random_stream(RANDOM_ITEMS / 8);
      drain_all();

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/wsp_pkg.sv
rtl/core/wsp_front.sv
rtl/core/wsp_queue.sv
rtl/core/wsp_div.sv
rtl/core/wsp_back.sv
rtl/core/world_to_screen_projection.sv
sim/testbench.sv
